@@ rtl/csvt_pkg.sv @@
// Shared types and constants for the CSV row field tokenizer.
package csvt_pkg;

    localparam int CSVT_MAX_FIELDS = 8;
    localparam int CSVT_QDEPTH     = 4;
    localparam int CSVT_ITEMS      = 3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [1:0] CFG_MAX_FIELDS  = 2'd0;
    localparam logic [1:0] CFG_MIN_FIELDS  = 2'd1;
    localparam logic [1:0] CFG_SKIP_HEADER = 2'd2;

    localparam logic [3:0] RST_MAX_FIELDS  = 4'd6;
    localparam logic [3:0] RST_MIN_FIELDS  = 4'd3;
    localparam logic       RST_SKIP_HEADER = 1'b1;

    typedef enum logic [4:0] {
        M_START = 5'b00001,
        M_UNQ   = 5'b00010,
        M_QUO   = 5'b00100,
        M_QSEEN = 5'b01000,
        M_SKIP  = 5'b10000
    } t_mode;

    typedef struct packed {
        logic       has;
        logic [7:0] data;
        logic [2:0] fnum;
        logic       fd;
        logic       rd;
        logic [3:0] cnt;
        logic       ok;
        logic       last;
    } t_item;

    // results of one input byte, slot 0 first
    typedef struct packed {
        t_item [CSVT_ITEMS-1:0] it;
        logic  [1:0]            n;
    } t_bundle;

endpackage

@@ rtl/csvt_front.sv @@
// Front end: parses one byte per cycle while i_acc is high and builds its bundle of result items.
module csvt_front
    import csvt_pkg::*;
#(
    parameter int MAX_FIELDS = CSVT_MAX_FIELDS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_stream,
    input  logic [3:0] i_max_fields,
    input  logic [3:0] i_min_fields,
    input  logic       i_skip_header,
    output logic       o_q_push,
    output t_bundle    o_bundle
);

    localparam int FI_MAX = (MAX_FIELDS < 15) ? MAX_FIELDS : 15;
    localparam int FIW    = $clog2(FI_MAX + 1);

    typedef struct packed {
        t_mode            mode;
        logic [FIW-1:0]   fidx;
        logic             nonblank;
    } t_ps;

    typedef struct packed {
        t_ps     s;
        t_bundle b;
    } t_cres;

    t_mode          r_mode, n_mode;
    logic [FIW-1:0] r_fidx, n_fidx;
    logic           r_pcr, n_pcr;
    logic           r_nonblank, n_nonblank;
    logic           r_hdr_pend, n_hdr_pend;

    logic [4:0]     lim;
    t_cres          c;
    t_bundle        bun;

    function automatic t_bundle f_emit(t_bundle b, logic has, logic [7:0] ch,
                                       logic [FIW-1:0] fi, logic fd, logic rd,
                                       logic [4:0] cnt, logic [3:0] minf);
        t_item      it;
        logic [4:0] fi5;
        fi5     = 5'(fi);
        it.has  = has;
        it.data = has ? ch : 8'h00;
        it.fnum = fi5[2:0];
        it.fd   = fd;
        it.rd   = rd;
        it.cnt  = rd ? cnt[3:0] : 4'd0;
        it.ok   = rd && (cnt >= {1'b0, minf});
        it.last = 1'b0;
        if (b.n != 2'd3) begin
            b.it[b.n] = it;
            b.n       = b.n + 2'd1;
        end
        return b;
    endfunction

    function automatic t_cres f_finish(t_cres x, logic [4:0] lm, logic [3:0] minf);
        x.b      = f_emit(x.b, 1'b0, 8'h00, x.s.fidx, 1'b1, 1'b0, 5'd0, minf);
        x.s.fidx = x.s.fidx + 1'b1;
        x.s.mode = (5'(x.s.fidx) >= lm) ? M_SKIP : M_START;
        return x;
    endfunction

    function automatic t_cres f_begin(t_cres x, logic [7:0] ch, logic [4:0] lm,
                                      logic [3:0] minf);
        if (ch == CH_CR || 5'(x.s.fidx) >= lm) begin
            x.s.mode = M_SKIP;
        end else if (ch == CH_QUOTE) begin
            x.s.mode = M_QUO;
        end else if (ch == CH_COMMA) begin
            x = f_finish(x, lm, minf);
        end else begin
            x.b      = f_emit(x.b, 1'b1, ch, x.s.fidx, 1'b0, 1'b0, 5'd0, minf);
            x.s.mode = M_UNQ;
        end
        return x;
    endfunction

    function automatic t_cres f_content(t_cres x, logic [7:0] ch, logic [4:0] lm,
                                        logic [3:0] minf);
        x.s.nonblank = 1'b1;
        unique case (x.s.mode)
            M_START: begin
                x = f_begin(x, ch, lm, minf);
            end
            M_UNQ: begin
                if (ch == CH_COMMA) begin
                    x = f_finish(x, lm, minf);
                end else if (ch == CH_CR) begin
                    x        = f_finish(x, lm, minf);
                    x.s.mode = M_SKIP;
                end else begin
                    x.b = f_emit(x.b, 1'b1, ch, x.s.fidx, 1'b0, 1'b0, 5'd0, minf);
                end
            end
            M_QUO: begin
                if (ch == CH_QUOTE) begin
                    x.s.mode = M_QSEEN;
                end else begin
                    x.b = f_emit(x.b, 1'b1, ch, x.s.fidx, 1'b0, 1'b0, 5'd0, minf);
                end
            end
            M_QSEEN: begin
                if (ch == CH_QUOTE) begin
                    x.b = f_emit(x.b, 1'b1, CH_QUOTE, x.s.fidx, 1'b0, 1'b0, 5'd0, minf);
                    x.s.mode = M_QUO;
                end else begin
                    x = f_finish(x, lm, minf);
                    if (ch != CH_COMMA && x.s.mode == M_START) begin
                        x = f_begin(x, ch, lm, minf);
                    end
                end
            end
            M_SKIP: begin
            end
            default: begin
            end
        endcase
        return x;
    endfunction

    function automatic t_cres f_end_row(t_cres x, logic [3:0] minf);
        if (x.s.nonblank) begin
            if (x.s.mode == M_UNQ || x.s.mode == M_QUO || x.s.mode == M_QSEEN) begin
                x.b = f_emit(x.b, 1'b0, 8'h00, x.s.fidx, 1'b1, 1'b1,
                             5'(x.s.fidx) + 5'd1, minf);
            end else begin
                x.b = f_emit(x.b, 1'b0, 8'h00, '0, 1'b0, 1'b1, 5'(x.s.fidx), minf);
            end
        end
        x.s.mode     = M_START;
        x.s.fidx     = '0;
        x.s.nonblank = 1'b0;
        return x;
    endfunction

    always_comb begin
        lim = ({1'b0, i_max_fields} > 5'(FI_MAX)) ? 5'(FI_MAX) : {1'b0, i_max_fields};

        c.s.mode     = r_mode;
        c.s.fidx     = r_fidx;
        c.s.nonblank = r_nonblank;
        c.b          = '0;
        n_pcr        = r_pcr;
        n_hdr_pend   = r_hdr_pend;

        if (i_data_byte == CH_LF) begin
            if (c.s.nonblank) begin
                n_hdr_pend = 1'b0;
            end
            c     = f_end_row(c, i_min_fields);
            n_pcr = 1'b0;
        end else begin
            if (n_pcr) begin
                n_pcr = 1'b0;
                c     = f_content(c, CH_CR, lim, i_min_fields);
            end
            if (i_data_byte == CH_CR) begin
                n_pcr = 1'b1;
            end else begin
                c = f_content(c, i_data_byte, lim, i_min_fields);
            end
        end

        if (i_end_of_stream) begin
            n_pcr      = 1'b0;
            c          = f_end_row(c, i_min_fields);
            n_hdr_pend = 1'b1;
        end

        n_mode     = c.s.mode;
        n_fidx     = c.s.fidx;
        n_nonblank = c.s.nonblank;

        bun = c.b;
        // header row gives nothing while skip_header is set
        if (r_hdr_pend && i_skip_header) begin
            bun.n = 2'd0;
        end
        if (bun.n != 2'd0) begin
            bun.it[bun.n - 2'd1].last = 1'b1;
        end
    end

    assign o_bundle = bun;
    assign o_q_push = i_acc && (bun.n != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_START;
            r_fidx     <= '0;
            r_pcr      <= 1'b0;
            r_nonblank <= 1'b0;
            r_hdr_pend <= 1'b1;
        end else if (i_acc) begin
            r_mode     <= n_mode;
            r_fidx     <= n_fidx;
            r_pcr      <= n_pcr;
            r_nonblank <= n_nonblank;
            r_hdr_pend <= n_hdr_pend;
        end
    end

endmodule

@@ rtl/csvt_queue.sv @@
// Bundle queue between the parser front end and the output back end.
module csvt_queue
    import csvt_pkg::*;
#(
    parameter int DEPTH = CSVT_QDEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_bundle o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!do_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/csvt_back.sv @@
// Back end: holds one bundle and hands its items out one per pop.
module csvt_back
    import csvt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_bundle i_q_head,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_item   o_item
);

    t_bundle    r_bun;
    logic [1:0] r_idx;
    logic       r_valid;
    logic       last_of;
    logic       load;

    assign last_of = (r_idx == r_bun.n - 2'd1);
    assign load    = !i_q_empty && (!r_valid || (i_pop && last_of));
    assign o_q_pop = load;
    assign o_empty = !r_valid;
    assign o_item  = r_bun.it[r_idx];

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bun <= i_q_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (i_pop && r_valid) begin
            if (last_of) begin
                r_valid <= 1'b0;
                r_idx   <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

@@ rtl/csv_row_field_tokenizer.sv @@
// Top level of the CSV row field tokenizer.
//
// Input channel: a byte of CSV text with an end_of_stream flag is taken at a
// rising edge with push high and full low. Each byte yields zero to three
// result items (content byte, field end, row end), all built in the cycle the
// byte is taken and, if any, written as one bundle into a small queue.
// Result channel: while empty is low the oldest item sits on the o_ ports; it
// is taken at an edge with pop high. With pop high, one item leaves per cycle.
// Throughput: one byte per cycle while full is low; a byte that makes several
// items holds the output until each of them has been popped.
// Path: the parser is combinational; the items of a taken byte are registered
// in the queue, then in the output holding register, before they reach the
// o_ ports.
// Stalls: with pop low the output holds; the queue (QUEUE_DEPTH bundles)
// keeps taking bytes until it fills, then full rises.
// Configuration: i_cfg_we writes register i_cfg_addr (0 max_fields,
// 1 min_fields, 2 skip_header) at once; write only while idle.
// Reset: synchronous, active low; registers return to 6, 3, 1, the queue
// empties and the parser expects a header row.
module csv_row_field_tokenizer
    import csvt_pkg::*;
#(
    parameter int MAX_FIELDS  = CSVT_MAX_FIELDS,
    parameter int QUEUE_DEPTH = CSVT_QDEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_stream,
    output logic       empty,
    input  logic       pop,
    output logic       o_has_byte,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_field_number,
    output logic       o_field_done,
    output logic       o_row_done,
    output logic [3:0] o_field_count,
    output logic       o_row_ok,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_addr,
    input  logic [3:0] i_cfg_wdata
);

    logic [3:0] r_max_fields;
    logic [3:0] r_min_fields;
    logic       r_skip_header;

    logic       acc;
    logic       q_push, q_pop, q_empty;
    t_bundle    f_bundle, q_head;
    t_item      item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fields  <= RST_MAX_FIELDS;
            r_min_fields  <= RST_MIN_FIELDS;
            r_skip_header <= RST_SKIP_HEADER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MAX_FIELDS:  r_max_fields  <= i_cfg_wdata;
                CFG_MIN_FIELDS:  r_min_fields  <= i_cfg_wdata;
                CFG_SKIP_HEADER: r_skip_header <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign acc = push && !full;

    csvt_front #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_acc           (acc),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_max_fields    (r_max_fields),
        .i_min_fields    (r_min_fields),
        .i_skip_header   (r_skip_header),
        .o_q_push        (q_push),
        .o_bundle        (f_bundle)
    );

    csvt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (f_bundle),
        .i_pop    (q_pop),
        .o_full   (full),
        .o_empty  (q_empty),
        .o_head   (q_head)
    );

    csvt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (item)
    );

    assign o_has_byte     = item.has;
    assign o_out_byte     = item.data;
    assign o_field_number = item.fnum;
    assign o_field_done   = item.fd;
    assign o_row_done     = item.rd;
    assign o_field_count  = item.cnt;
    assign o_row_ok       = item.ok;
    assign o_last         = item.last;

endmodule

@@ rtl/csvt_checker.sv @@
// Port-level checks for the CSV row field tokenizer, bound to the top level.
module csvt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic       o_has_byte,
    input logic [7:0] o_out_byte,
    input logic [2:0] o_field_number,
    input logic       o_field_done,
    input logic       o_row_done,
    input logic [3:0] o_field_count,
    input logic       o_row_ok,
    input logic       o_last
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable({o_has_byte, o_out_byte,
            o_field_number, o_field_done, o_row_done, o_field_count,
            o_row_ok, o_last})))
        else $error("stalled item changed");

    a_row_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_row_done) |-> (o_field_count == 4'd0 && !o_row_ok))
        else $error("row count or flag outside a row end");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_has_byte) |-> (o_out_byte == 8'h00))
        else $error("byte set on an item without content");

    a_row_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_row_done) |-> o_last)
        else $error("row end not the last item of its byte");

endmodule

bind csv_row_field_tokenizer csvt_checker u_chk (.*);
